### src/jnl_pkg.sv
`default_nettype none

package jnl_pkg;

    // field widths fixed by the token format
    localparam int CH_W    = 8;
    localparam int DVAL_W  = 4;
    localparam int ERR_W   = 3;
    localparam int MANT_W  = 64;
    localparam int EXPA_W  = 14;
    localparam int DEXP_W  = 15;
    localparam int CNT_W   = 5;

    // queue between classifier and parser
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // characters of the number grammar
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CH_W-1:0] CH_LO_E  = 8'h65;
    localparam logic [CH_W-1:0] CH_UP_E  = 8'h45;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0d;

    // error codes of a result beat
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_START = 3'd1;
    localparam logic [ERR_W-1:0] ERR_LEAD_ZERO = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NO_DIGIT  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_CHAR  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_TOO_MANY  = 3'd5;

    // character class decided by the front end
    typedef enum logic [2:0] {
        K_DIGIT = 3'd0,
        K_DOT   = 3'd1,
        K_EXP   = 3'd2,
        K_MINUS = 3'd3,
        K_PLUS  = 3'd4,
        K_SPACE = 3'd5,
        K_OTHER = 3'd6
    } kind_t;

    // classified character as queued for the parser
    typedef struct packed {
        logic              start;
        kind_t             kind;
        logic [DVAL_W-1:0] dval;
    } tok_t;

    // parser phases
    typedef enum logic [9:0] {
        PH_IDLE  = 10'b00_0000_0001,
        PH_START = 10'b00_0000_0010,
        PH_SIGN  = 10'b00_0000_0100,
        PH_ZERO  = 10'b00_0000_1000,
        PH_INT   = 10'b00_0001_0000,
        PH_DOT   = 10'b00_0010_0000,
        PH_FRAC  = 10'b00_0100_0000,
        PH_EXPE  = 10'b00_1000_0000,
        PH_EXPS  = 10'b01_0000_0000,
        PH_EXP   = 10'b10_0000_0000
    } phase_t;

    // largest exponent with n decimal digits, n capped at four
    function automatic logic [EXPA_W-1:0] exp_cap_f(input int n);
        int cap;
        cap = 1;
        for (int i = 0; i < n && i < 4; i++)
        begin
            cap = cap * 10;
        end
        return EXPA_W'(cap - 1);
    endfunction

endpackage

`default_nettype wire

### src/json_number_lexer_core.sv
// json number lexer
// input stream: one character per beat, s_axis_tdata = ch, s_axis_tuser marks
// the first character of a token; a beat is taken when tvalid and tready are high
// output stream: one beat per finished token, a number or an error code; a
// whitespace character ends a number, a grammar violation ends it with an error
// throughput: one character per cycle while the queue has room; the classifier
// feeds a four-entry queue and the parser retires one queued character per
// cycle unless its result cannot be stored, with its 64-bit times-ten
// accumulate as the per-cycle step
// result path: the terminating character is written to the queue, then the
// parser step moves its result into the output register
// stall: a waiting result holds in the output register; the parser keeps
// retiring characters that give no result, and the queue fills before
// s_axis_tready drops
// reset: asynchronous, active low; clears the queue, the parser to idle and
// the output valid; characters before a token start give no result
`default_nettype none

module json_number_lexer_core
    import jnl_pkg::*;
#(
    parameter int MAX_INT_DIGITS = 19,
    parameter int MAX_EXP_DIGITS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tuser,   // [0] start_token
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata    // [2:0] error, [3] negative,
                                             // [67:4] mantissa,
                                             // [82:68] dec_exponent, [87:83] zero
);

    logic               q_full;
    logic               q_push;
    tok_t               q_tok;
    logic               q_pop;
    logic               head_valid;
    tok_t               head_tok;
    logic [ERR_W-1:0]   error;
    logic               negative;
    logic [MANT_W-1:0]  mantissa;
    logic [DEXP_W-1:0]  dec_exponent;

    // classifier
    jnl_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .ch            (s_axis_tdata),
        .start_token   (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_tok         (q_tok)
    );

    // queue between classifier and parser
    jnl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_tok   (q_tok),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_tok   (head_tok)
    );

    // parser and result register
    jnl_back #(
        .MAX_INT_DIGITS (MAX_INT_DIGITS),
        .MAX_EXP_DIGITS (MAX_EXP_DIGITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_tok      (head_tok),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .error         (error),
        .negative      (negative),
        .mantissa      (mantissa),
        .dec_exponent  (dec_exponent)
    );

    // pack the result beat
    assign m_axis_tdata = {5'b00000, dec_exponent, mantissa, negative, error};

endmodule

`default_nettype wire

### src/jnl_front.sv
`default_nettype none

module jnl_front
    import jnl_pkg::*;
(
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [CH_W-1:0] ch,
    input  wire logic            start_token,
    input  wire logic            q_full,
    output logic                 q_push,
    output tok_t                 q_tok
);

    logic ch_numeral;

    // take a beat whenever the queue has room
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // classify the character
    assign ch_numeral = (ch >= CH_ZERO) && (ch <= CH_NINE);

    always_comb
    begin
        q_tok.start = start_token;
        q_tok.dval  = ch[DVAL_W-1:0];
        if (ch_numeral)
        begin
            q_tok.kind = K_DIGIT;
        end
        else if (ch == CH_DOT)
        begin
            q_tok.kind = K_DOT;
        end
        else if (ch == CH_LO_E || ch == CH_UP_E)
        begin
            q_tok.kind = K_EXP;
        end
        else if (ch == CH_MINUS)
        begin
            q_tok.kind = K_MINUS;
        end
        else if (ch == CH_PLUS)
        begin
            q_tok.kind = K_PLUS;
        end
        else if (ch == CH_SPACE || ch == CH_LF || ch == CH_TAB || ch == CH_CR)
        begin
            q_tok.kind = K_SPACE;
        end
        else
        begin
            q_tok.kind = K_OTHER;
        end
    end

endmodule

`default_nettype wire

### src/jnl_queue.sv
`default_nettype none

module jnl_queue
    import jnl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  tok_t      push_tok,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output tok_t      head_tok
);

    tok_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_tok   = slot_reg[rd_ptr_reg];

    // occupancy follows push and pop
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

`default_nettype wire

### src/jnl_back.sv
`default_nettype none

module jnl_back
    import jnl_pkg::*;
#(
    parameter int MAX_INT_DIGITS = 19,
    parameter int MAX_EXP_DIGITS = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  tok_t                   head_tok,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [ERR_W-1:0]       error,
    output logic                   negative,
    output logic [MANT_W-1:0]      mantissa,
    output logic [DEXP_W-1:0]      dec_exponent
);

    localparam logic [CNT_W-1:0]  MAX_INT = CNT_W'(MAX_INT_DIGITS);
    localparam logic [EXPA_W-1:0] EXP_CAP = exp_cap_f(MAX_EXP_DIGITS);

    phase_t              phase_reg, phase_next, ph_eff;
    logic                neg_reg, neg_next, neg_eff;
    logic [MANT_W-1:0]   mant_reg, mant_next, mant_eff;
    logic [CNT_W-1:0]    icnt_reg, icnt_next, icnt_eff;
    logic [CNT_W-1:0]    fkept_reg, fkept_next, fkept_eff;
    logic [EXPA_W-1:0]   exp_reg, exp_next, exp_eff;
    logic                eneg_reg, eneg_next, eneg_eff;

    logic                out_valid_reg;
    logic [ERR_W-1:0]    out_err_reg;
    logic                out_neg_reg;
    logic [MANT_W-1:0]   out_mant_reg;
    logic [DEXP_W-1:0]   out_dexp_reg;

    logic                emit;
    logic [ERR_W-1:0]    emit_err;
    logic                sign_go;
    logic                exps_go;
    logic                take_int;
    logic                take_frac;
    logic                take_exp;
    logic                is_dig;
    logic [MANT_W-1:0]   mant_mac;
    logic [CNT_W:0]      digit_sum;
    logic [EXPA_W+2:0]   exp_mac;
    logic signed [DEXP_W:0] exp_signed;
    logic signed [DEXP_W:0] dexp_full;
    logic                out_free;

    // a token start drops whatever number was in progress
    always_comb
    begin
        if (head_tok.start)
        begin
            ph_eff    = PH_START;
            neg_eff   = 1'b0;
            mant_eff  = '0;
            icnt_eff  = '0;
            fkept_eff = '0;
            exp_eff   = '0;
            eneg_eff  = 1'b0;
        end
        else
        begin
            ph_eff    = phase_reg;
            neg_eff   = neg_reg;
            mant_eff  = mant_reg;
            icnt_eff  = icnt_reg;
            fkept_eff = fkept_reg;
            exp_eff   = exp_reg;
            eneg_eff  = eneg_reg;
        end
    end

    // decimal accumulate: times ten plus digit
    assign is_dig    = (head_tok.kind == K_DIGIT);
    assign mant_mac  = (mant_eff << 3) + (mant_eff << 1) + MANT_W'(head_tok.dval);
    assign digit_sum = {1'b0, icnt_eff} + {1'b0, fkept_eff};
    assign exp_mac   = ({3'b000, exp_eff} << 3) + ({3'b000, exp_eff} << 1)
                     + (EXPA_W+3)'(head_tok.dval);

    // final exponent: signed exponent minus kept fraction digits
    assign exp_signed = eneg_eff ? -$signed({2'b00, exp_eff}) : $signed({2'b00, exp_eff});
    assign dexp_full  = exp_signed - $signed({{(DEXP_W+1-CNT_W){1'b0}}, fkept_eff});

    // grammar walk and accumulators
    always_comb
    begin
        phase_next = ph_eff;
        neg_next   = neg_eff;
        eneg_next  = eneg_eff;
        emit       = 1'b0;
        emit_err   = ERR_NONE;
        sign_go    = 1'b0;
        exps_go    = 1'b0;
        take_int   = 1'b0;
        take_frac  = 1'b0;
        take_exp   = 1'b0;
        case (ph_eff)
            PH_START:
            begin
                if (head_tok.kind == K_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_SIGN;
                end
                else
                begin
                    sign_go = 1'b1;
                end
            end
            PH_SIGN:
            begin
                sign_go = 1'b1;
            end
            PH_ZERO, PH_INT:
            begin
                if (is_dig)
                begin
                    if (ph_eff == PH_ZERO)
                    begin
                        emit     = 1'b1;
                        emit_err = ERR_LEAD_ZERO;
                    end
                    else if (icnt_eff >= MAX_INT)
                    begin
                        emit     = 1'b1;
                        emit_err = ERR_TOO_MANY;
                    end
                    else
                    begin
                        take_int = 1'b1;
                    end
                end
                else if (head_tok.kind == K_DOT)
                begin
                    phase_next = PH_DOT;
                end
                else if (head_tok.kind == K_EXP)
                begin
                    phase_next = PH_EXPE;
                end
                else if (head_tok.kind == K_SPACE)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    emit     = 1'b1;
                    emit_err = ERR_BAD_CHAR;
                end
            end
            PH_DOT:
            begin
                if (is_dig)
                begin
                    take_frac = 1'b1;
                end
                else
                begin
                    emit     = 1'b1;
                    emit_err = ERR_NO_DIGIT;
                end
            end
            PH_FRAC:
            begin
                if (is_dig)
                begin
                    take_frac = 1'b1;
                end
                else if (head_tok.kind == K_EXP)
                begin
                    phase_next = PH_EXPE;
                end
                else if (head_tok.kind == K_SPACE)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    emit     = 1'b1;
                    emit_err = ERR_BAD_CHAR;
                end
            end
            PH_EXPE:
            begin
                if (head_tok.kind == K_MINUS)
                begin
                    eneg_next  = 1'b1;
                    phase_next = PH_EXPS;
                end
                else if (head_tok.kind == K_PLUS)
                begin
                    phase_next = PH_EXPS;
                end
                else
                begin
                    exps_go = 1'b1;
                end
            end
            PH_EXPS:
            begin
                exps_go = 1'b1;
            end
            PH_EXP:
            begin
                if (is_dig)
                begin
                    take_exp = 1'b1;
                end
                else if (head_tok.kind == K_SPACE)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    emit     = 1'b1;
                    emit_err = ERR_BAD_CHAR;
                end
            end
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // first integer digit, after the optional minus
        if (sign_go)
        begin
            if (is_dig && head_tok.dval == '0)
            begin
                phase_next = PH_ZERO;
            end
            else if (is_dig)
            begin
                take_int = 1'b1;
            end
            else
            begin
                emit     = 1'b1;
                emit_err = ERR_BAD_START;
            end
        end

        // first exponent digit, after the optional sign
        if (exps_go)
        begin
            if (is_dig)
            begin
                take_exp = 1'b1;
            end
            else
            begin
                emit     = 1'b1;
                emit_err = ERR_NO_DIGIT;
            end
        end

        // accumulators
        mant_next  = mant_eff;
        icnt_next  = icnt_eff;
        fkept_next = fkept_eff;
        exp_next   = exp_eff;
        if (take_int)
        begin
            mant_next  = mant_mac;
            icnt_next  = icnt_eff + 1'b1;
            phase_next = PH_INT;
        end
        if (take_frac)
        begin
            if (digit_sum < {1'b0, MAX_INT})
            begin
                mant_next  = mant_mac;
                fkept_next = fkept_eff + 1'b1;
            end
            phase_next = PH_FRAC;
        end
        if (take_exp)
        begin
            exp_next   = (exp_mac > {3'b000, EXP_CAP}) ? EXP_CAP : exp_mac[EXPA_W-1:0];
            phase_next = PH_EXP;
        end
        if (emit)
        begin
            phase_next = PH_IDLE;
            neg_next   = 1'b0;
            mant_next  = '0;
            icnt_next  = '0;
            fkept_next = '0;
            exp_next   = '0;
            eneg_next  = 1'b0;
        end
    end

    // a beat moves on unless its result cannot be stored
    assign out_free = !out_valid_reg || m_axis_tready;
    assign pop      = head_valid && (!emit || out_free);

    // token state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            neg_reg   <= 1'b0;
            mant_reg  <= '0;
            icnt_reg  <= '0;
            fkept_reg <= '0;
            exp_reg   <= '0;
            eneg_reg  <= 1'b0;
        end
        else if (pop)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mant_reg  <= mant_next;
            icnt_reg  <= icnt_next;
            fkept_reg <= fkept_next;
            exp_reg   <= exp_next;
            eneg_reg  <= eneg_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, zero fields on error
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_err_reg <= emit_err;
            if (emit_err == ERR_NONE)
            begin
                out_neg_reg  <= neg_eff;
                out_mant_reg <= mant_eff;
                out_dexp_reg <= dexp_full[DEXP_W-1:0];
            end
            else
            begin
                out_neg_reg  <= 1'b0;
                out_mant_reg <= '0;
                out_dexp_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign error         = out_err_reg;
    assign negative      = out_neg_reg;
    assign mantissa      = out_mant_reg;
    assign dec_exponent  = out_dexp_reg;

endmodule

`default_nettype wire
